FILE: src/asde_pkg.sv
// Shared types, constants and helper functions for the ANSI screen diff encoder.
// Used by the channel interfaces and by ansi_screen_diff_encoder_core; no dependencies.
package asde_pkg;

	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);

	localparam logic [7:0] ROWS_RESET = 8'd24;
	localparam logic [7:0] COLS_RESET = 8'd80;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [6:0] FG_DEFAULT = 7'd39;
	localparam logic [6:0] FG_BASE    = 7'd30;
	localparam logic [6:0] BG_DEFAULT = 7'd49;
	localparam logic [6:0] BG_BASE    = 7'd40;

	// Byte slots of the longest sequence one cell can cause.
	localparam int SL_P_ESC  = 0;
	localparam int SL_P_LBRK = 1;
	localparam int SL_R_HUN  = 2;
	localparam int SL_R_TEN  = 3;
	localparam int SL_R_ONE  = 4;
	localparam int SL_P_SEMI = 5;
	localparam int SL_C_HUN  = 6;
	localparam int SL_C_TEN  = 7;
	localparam int SL_C_ONE  = 8;
	localparam int SL_P_H    = 9;
	localparam int SL_K_ESC  = 10;
	localparam int SL_K_LBRK = 11;
	localparam int SL_F_TEN  = 12;
	localparam int SL_F_ONE  = 13;
	localparam int SL_K_SEMI = 14;
	localparam int SL_B_TEN  = 15;
	localparam int SL_B_ONE  = 16;
	localparam int SL_K_M    = 17;
	localparam int SL_CHAR   = 18;
	localparam int SL_E_ESC  = 19;
	localparam int SL_E_LBRK = 20;
	localparam int SL_E_ZERO = 21;
	localparam int SL_E_M    = 22;
	localparam int SLOT_COUNT = 23;

	typedef logic [SLOT_COUNT-1:0] slot_mask_t;
	typedef logic [7:0] slot_bytes_t [SLOT_COUNT];

	typedef struct packed {
		logic [3:0] hun;
		logic [3:0] ten;
		logic [3:0] one;
	} digits_t;

	// Decimal digits of a value up to 256.
	function automatic digits_t dec3(input logic [8:0] v);
		digits_t d;
		logic [6:0] rem;
		logic [14:0] prod;
		if (v >= 9'd200) begin
			d.hun = 4'd2;
			rem = 7'(v - 9'd200);
		end else if (v >= 9'd100) begin
			d.hun = 4'd1;
			rem = 7'(v - 9'd100);
		end else begin
			d.hun = 4'd0;
			rem = 7'(v);
		end
		prod = 15'(rem) * 15'd205;
		d.ten = 4'(prod >> 11);
		d.one = 4'(rem - 7'(d.ten) * 7'd10);
		return d;
	endfunction

	function automatic logic [6:0] fg_code(input logic [3:0] fg);
		return (fg == 4'd0) ? FG_DEFAULT : FG_BASE + 7'(fg) - 7'd1;
	endfunction

	function automatic logic [6:0] bg_code(input logic [3:0] bg);
		return (bg == 4'd0) ? BG_DEFAULT : BG_BASE + 7'(bg) - 7'd1;
	endfunction

	function automatic logic [7:0] ascii_digit(input logic [3:0] d);
		return CH_ZERO | {4'b0, d};
	endfunction

endpackage

FILE: src/asde_chans.sv
// Valid/ready channel interfaces of the ANSI screen diff encoder: cells in, bytes out, config.
// Depends on asde_pkg for the configuration index width.
interface asde_cell_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_char;
	logic [3:0] cell_fg;
	logic [3:0] cell_bg;
	modport source (output valid, output cell_char, output cell_fg, output cell_bg, input ready);
	modport sink (input valid, input cell_char, input cell_fg, input cell_bg, output ready);
endinterface

interface asde_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

interface asde_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [asde_pkg::CFG_IDX_W-1:0] reg_index;
	logic [7:0]                     wdata;
	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: src/ansi_screen_diff_encoder_core.sv
// ANSI screen diff encoder: compares each cell with a shadow frame in block RAM and emits
// cursor, color and character bytes for changed cells, plus a reset sequence at each frame end.
// Uses asde_pkg and asde_chans. A cell is registered in stage 1, its bytes in stage 2.
// Throughput: one cell per cycle while cells cause no bytes; a cell that causes bytes
// (up to 23) holds the output stage until its last byte goes, one per cycle while ready.
// Reset: every shadow RAM entry is then cleared; cell requests wait, config does not.
module ansi_screen_diff_encoder_core #(
	parameter int MAX_CELLS = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	asde_cell_if.sink            cells,
	asde_byte_if.source          text,
	asde_cfg_if.sink             cfg
);

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	logic [7:0] rows_q, cols_q;
	logic [7:0] row_q, col_q;
	logic [7:0] rows_eff, cols_eff;
	logic       row_end, frame_end;
	logic [15:0] idx;
	logic       stored;
	logic [AW-1:0] addr;
	logic       accept;

	logic       clearing_q;
	logic [AW-1:0] clr_addr_q;

	logic [15:0] shadow_mem [MAX_CELLS];
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0] mem_wdata;

	logic        s1_valid_q;
	logic [7:0]  char_s1;
	logic [3:0]  fg_s1, bg_s1;
	logic [7:0]  row_s1, col_s1;
	logic        stored_s1, fend_s1;
	logic [AW-1:0] addr_s1;
	logic [15:0] shadow_rd_s1;
	logic        fwd_hit_s1;
	logic [15:0] fwd_word_s1;

	logic [15:0] word_s1, shadow_s1;
	logic        changed, pos_need, col_need, mask_empty, s1_adv;

	logic        last_pos_valid_q, last_color_valid_q;
	logic [7:0]  last_row_q, last_col_q;
	logic [3:0]  last_fg_q, last_bg_q;

	asde_pkg::digits_t  rdig, cdig, fdig, bdig;
	asde_pkg::slot_mask_t mask_nx;
	asde_pkg::slot_bytes_t bytes_nx;

	asde_pkg::slot_mask_t mask_s2, pick;
	asde_pkg::slot_bytes_t byte_s2;
	logic        s2_free;

	// Configuration.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= asde_pkg::ROWS_RESET;
			cols_q <= asde_pkg::COLS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				asde_pkg::REG_FRAME_ROWS: rows_q <= cfg.wdata;
				asde_pkg::REG_FRAME_COLS: cols_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Raster position and shadow address of the incoming cell.
	always_comb begin
		rows_eff = (rows_q == 8'd0) ? 8'd1 : rows_q;
		cols_eff = (cols_q == 8'd0) ? 8'd1 : cols_q;
		row_end = ({1'b0, col_q} + 9'd1) >= {1'b0, cols_eff};
		frame_end = row_end && (({1'b0, row_q} + 9'd1) >= {1'b0, rows_eff});
		idx = 16'(row_q) * 16'(cols_eff) + 16'(col_q);
		stored = {1'b0, idx} < 17'(MAX_CELLS);
		addr = idx[AW-1:0];
	end

	assign cells.ready = !clearing_q && (!s1_valid_q || s1_adv);
	assign accept = cells.valid && cells.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 8'd0;
			col_q <= 8'd0;
		end else if (accept) begin
			if (frame_end) begin
				row_q <= 8'd0;
				col_q <= 8'd0;
			end else if (row_end) begin
				row_q <= row_q + 8'd1;
				col_q <= 8'd0;
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

	// Clearing pass over the shadow RAM after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_CELLS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Shadow RAM: one write port, one registered read port.
	assign mem_we = clearing_q || (s1_adv && changed && stored_s1);
	assign mem_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clearing_q ? 16'd0 : word_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			shadow_mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			shadow_rd_s1 <= shadow_mem[addr];
		end
	end

	// Stage 1: compare against the shadow entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// The write of the leaving cell lands on the same edge as the read of the next one.
	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= cells.cell_char;
			fg_s1 <= cells.cell_fg;
			bg_s1 <= cells.cell_bg;
			row_s1 <= row_q;
			col_s1 <= col_q;
			stored_s1 <= stored;
			fend_s1 <= frame_end;
			addr_s1 <= addr;
			fwd_hit_s1 <= s1_adv && changed && stored_s1 && (addr_s1 == addr);
			fwd_word_s1 <= word_s1;
		end
	end

	always_comb begin
		word_s1 = {char_s1, fg_s1, bg_s1};
		shadow_s1 = fwd_hit_s1 ? fwd_word_s1 : shadow_rd_s1;
		changed = !stored_s1 || (shadow_s1 != word_s1);
		pos_need = !last_pos_valid_q || (row_s1 != last_row_q) || (col_s1 != last_col_q);
		col_need = !last_color_valid_q || (fg_s1 != last_fg_q) || (bg_s1 != last_bg_q);
		mask_empty = !changed && !fend_s1;
	end

	// Byte slots for the cell in stage 1.
	always_comb begin
		rdig = asde_pkg::dec3(9'(row_s1) + 9'd1);
		cdig = asde_pkg::dec3(9'(col_s1) + 9'd1);
		fdig = asde_pkg::dec3(9'(asde_pkg::fg_code(fg_s1)));
		bdig = asde_pkg::dec3(9'(asde_pkg::bg_code(bg_s1)));

		bytes_nx[asde_pkg::SL_P_ESC]  = asde_pkg::CH_ESC;
		bytes_nx[asde_pkg::SL_P_LBRK] = asde_pkg::CH_LBRK;
		bytes_nx[asde_pkg::SL_R_HUN]  = asde_pkg::ascii_digit(rdig.hun);
		bytes_nx[asde_pkg::SL_R_TEN]  = asde_pkg::ascii_digit(rdig.ten);
		bytes_nx[asde_pkg::SL_R_ONE]  = asde_pkg::ascii_digit(rdig.one);
		bytes_nx[asde_pkg::SL_P_SEMI] = asde_pkg::CH_SEMI;
		bytes_nx[asde_pkg::SL_C_HUN]  = asde_pkg::ascii_digit(cdig.hun);
		bytes_nx[asde_pkg::SL_C_TEN]  = asde_pkg::ascii_digit(cdig.ten);
		bytes_nx[asde_pkg::SL_C_ONE]  = asde_pkg::ascii_digit(cdig.one);
		bytes_nx[asde_pkg::SL_P_H]    = asde_pkg::CH_H;
		bytes_nx[asde_pkg::SL_K_ESC]  = asde_pkg::CH_ESC;
		bytes_nx[asde_pkg::SL_K_LBRK] = asde_pkg::CH_LBRK;
		bytes_nx[asde_pkg::SL_F_TEN]  = asde_pkg::ascii_digit(fdig.ten);
		bytes_nx[asde_pkg::SL_F_ONE]  = asde_pkg::ascii_digit(fdig.one);
		bytes_nx[asde_pkg::SL_K_SEMI] = asde_pkg::CH_SEMI;
		bytes_nx[asde_pkg::SL_B_TEN]  = asde_pkg::ascii_digit(bdig.ten);
		bytes_nx[asde_pkg::SL_B_ONE]  = asde_pkg::ascii_digit(bdig.one);
		bytes_nx[asde_pkg::SL_K_M]    = asde_pkg::CH_M;
		bytes_nx[asde_pkg::SL_CHAR]   = char_s1;
		bytes_nx[asde_pkg::SL_E_ESC]  = asde_pkg::CH_ESC;
		bytes_nx[asde_pkg::SL_E_LBRK] = asde_pkg::CH_LBRK;
		bytes_nx[asde_pkg::SL_E_ZERO] = asde_pkg::CH_ZERO;
		bytes_nx[asde_pkg::SL_E_M]    = asde_pkg::CH_M;

		mask_nx = '0;
		if (changed && pos_need) begin
			mask_nx[asde_pkg::SL_P_ESC]  = 1'b1;
			mask_nx[asde_pkg::SL_P_LBRK] = 1'b1;
			mask_nx[asde_pkg::SL_R_HUN]  = (rdig.hun != 4'd0);
			mask_nx[asde_pkg::SL_R_TEN]  = (rdig.hun != 4'd0) || (rdig.ten != 4'd0);
			mask_nx[asde_pkg::SL_R_ONE]  = 1'b1;
			mask_nx[asde_pkg::SL_P_SEMI] = 1'b1;
			mask_nx[asde_pkg::SL_C_HUN]  = (cdig.hun != 4'd0);
			mask_nx[asde_pkg::SL_C_TEN]  = (cdig.hun != 4'd0) || (cdig.ten != 4'd0);
			mask_nx[asde_pkg::SL_C_ONE]  = 1'b1;
			mask_nx[asde_pkg::SL_P_H]    = 1'b1;
		end
		if (changed && col_need) begin
			mask_nx[asde_pkg::SL_K_ESC]  = 1'b1;
			mask_nx[asde_pkg::SL_K_LBRK] = 1'b1;
			mask_nx[asde_pkg::SL_F_TEN]  = 1'b1;
			mask_nx[asde_pkg::SL_F_ONE]  = 1'b1;
			mask_nx[asde_pkg::SL_K_SEMI] = 1'b1;
			mask_nx[asde_pkg::SL_B_TEN]  = 1'b1;
			mask_nx[asde_pkg::SL_B_ONE]  = 1'b1;
			mask_nx[asde_pkg::SL_K_M]    = 1'b1;
		end
		mask_nx[asde_pkg::SL_CHAR] = changed;
		mask_nx[asde_pkg::SL_E_ESC]  = fend_s1;
		mask_nx[asde_pkg::SL_E_LBRK] = fend_s1;
		mask_nx[asde_pkg::SL_E_ZERO] = fend_s1;
		mask_nx[asde_pkg::SL_E_M]    = fend_s1;
	end

	assign s2_free = (mask_s2 == '0) || (text.ready && text.run_last);
	assign s1_adv = s1_valid_q && (mask_empty || s2_free);

	// Cursor and color memory, updated in cell order as cells leave stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_valid_q <= 1'b0;
			last_row_q <= 8'd0;
			last_col_q <= 8'd0;
			last_color_valid_q <= 1'b0;
			last_fg_q <= 4'd0;
			last_bg_q <= 4'd0;
		end else if (s1_adv) begin
			if (fend_s1) begin
				last_pos_valid_q <= 1'b0;
				last_row_q <= 8'd0;
				last_col_q <= 8'd0;
				last_color_valid_q <= 1'b0;
				last_fg_q <= 4'd0;
				last_bg_q <= 4'd0;
			end else if (changed) begin
				last_pos_valid_q <= 1'b1;
				last_row_q <= row_s1;
				last_col_q <= col_s1 + 8'd1;
				if (col_need) begin
					last_color_valid_q <= 1'b1;
					last_fg_q <= fg_s1;
					last_bg_q <= bg_s1;
				end
			end
		end
	end

	// Stage 2: output slots, drained lowest slot first.
	assign pick = mask_s2 & (~mask_s2 + asde_pkg::SLOT_COUNT'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (s1_adv && !mask_empty) begin
			mask_s2 <= mask_nx;
		end else if (text.ready) begin
			mask_s2 <= mask_s2 & ~pick;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && !mask_empty) begin
			byte_s2 <= bytes_nx;
		end
	end

	always_comb begin
		text.out_byte = 8'd0;
		for (int i = 0; i < asde_pkg::SLOT_COUNT; i++) begin
			text.out_byte = text.out_byte | (pick[i] ? byte_s2[i] : 8'd0);
		end
	end

	assign text.valid = (mask_s2 != '0);
	assign text.run_last = ((mask_s2 & ~pick) == '0);

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for ansi_screen_diff_encoder_core: frames of cells go in over the cell
// channel and every output byte is checked against a local predictor of the screen diff encoding.
// Depends on asde_pkg, the channel interfaces in asde_chans and the core module.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CELLS = 2048;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_PCT = 38;
	localparam int RANDOM_CELLS = 370;
	localparam int MAX_REPORTS = 40;

	localparam logic [asde_pkg::CFG_IDX_W-1:0] REG_SPARE = asde_pkg::CFG_IDX_W'(2);
	localparam logic [asde_pkg::CFG_IDX_W-1:0] REG_TOP = '1;

	typedef struct packed {
		logic [7:0] ch;
		logic [3:0] fg;
		logic [3:0] bg;
	} cell_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	asde_cell_if cell_bus();
	asde_byte_if text_bus();
	asde_cfg_if cfg_bus();

	ansi_screen_diff_encoder_core #(.MAX_CELLS(MAX_CELLS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cells(cell_bus),
		.text(text_bus),
		.cfg(cfg_bus)
	);

	always #10 clk = ~clk;

	// Cells waiting for the driver, and the bytes the encoder still owes.
	cell_t pending_cells[$];
	text_byte_t text_due[$];
	logic [7:0] burst[$];

	// Predicted encoder state.
	logic [15:0] shadow_mirror [MAX_CELLS];
	logic [7:0] rows_reg, cols_reg;
	logic [7:0] at_row, at_col;
	logic cur_valid;
	logic [7:0] cur_row, cur_col;
	logic pen_valid;
	logic [3:0] pen_fg, pen_bg;

	// What the generator believes the screen holds, used to build mostly unchanged frames.
	cell_t gen_image [MAX_CELLS];

	int errors = 0;
	int cells_queued = 0;
	int cells_taken = 0;
	int random_cells = 0;
	int bytes_checked = 0;
	int frames_closed = 0;
	logic cell_took = 1'b0;
	logic no_gaps = 1'b0;
	cell_t next_cell;
	text_byte_t want;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic put_dec(input int v);
		if (v >= 100)
			burst.push_back(asde_pkg::CH_ZERO + 8'((v / 100) % 10));
		if (v >= 10)
			burst.push_back(asde_pkg::CH_ZERO + 8'((v / 10) % 10));
		burst.push_back(asde_pkg::CH_ZERO + 8'(v % 10));
	endtask

	task automatic encode_cell(input cell_t c);
		int nrows, ncols, idx;
		logic [15:0] word;
		bit stored, row_end, frame_end;
		text_byte_t tb;
		nrows = (rows_reg == 8'd0) ? 1 : int'(rows_reg);
		ncols = (cols_reg == 8'd0) ? 1 : int'(cols_reg);
		idx = int'(at_row) * ncols + int'(at_col);
		word = c;
		stored = idx < MAX_CELLS;
		row_end = int'(at_col) + 1 >= ncols;
		frame_end = row_end && (int'(at_row) + 1 >= nrows);
		burst.delete();
		if (!stored || shadow_mirror[idx] != word) begin
			if (!cur_valid || at_row != cur_row || at_col != cur_col) begin
				burst.push_back(asde_pkg::CH_ESC);
				burst.push_back(asde_pkg::CH_LBRK);
				put_dec(int'(at_row) + 1);
				burst.push_back(asde_pkg::CH_SEMI);
				put_dec(int'(at_col) + 1);
				burst.push_back(asde_pkg::CH_H);
			end
			if (!pen_valid || c.fg != pen_fg || c.bg != pen_bg) begin
				burst.push_back(asde_pkg::CH_ESC);
				burst.push_back(asde_pkg::CH_LBRK);
				put_dec((c.fg == 4'd0) ? int'(asde_pkg::FG_DEFAULT)
					: int'(asde_pkg::FG_BASE) + int'(c.fg) - 1);
				burst.push_back(asde_pkg::CH_SEMI);
				put_dec((c.bg == 4'd0) ? int'(asde_pkg::BG_DEFAULT)
					: int'(asde_pkg::BG_BASE) + int'(c.bg) - 1);
				burst.push_back(asde_pkg::CH_M);
				pen_valid = 1'b1;
				pen_fg = c.fg;
				pen_bg = c.bg;
			end
			burst.push_back(c.ch);
			cur_valid = 1'b1;
			cur_row = at_row;
			cur_col = at_col + 8'd1;
			if (stored)
				shadow_mirror[idx] = word;
		end
		if (frame_end) begin
			burst.push_back(asde_pkg::CH_ESC);
			burst.push_back(asde_pkg::CH_LBRK);
			burst.push_back(asde_pkg::CH_ZERO);
			burst.push_back(asde_pkg::CH_M);
			cur_valid = 1'b0;
			cur_row = '0;
			cur_col = '0;
			pen_valid = 1'b0;
			pen_fg = '0;
			pen_bg = '0;
			at_row = '0;
			at_col = '0;
			frames_closed++;
		end else if (row_end) begin
			at_col = '0;
			at_row = at_row + 8'd1;
		end else begin
			at_col = at_col + 8'd1;
		end
		foreach (burst[i]) begin
			tb.code = burst[i];
			tb.last = (i == burst.size() - 1);
			text_due.push_back(tb);
		end
	endtask

	// Driver: new requests and output back-pressure change on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cell_bus.valid || cell_took) begin
				if (pending_cells.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
					next_cell = pending_cells.pop_front();
					cell_bus.valid <= 1'b1;
					cell_bus.cell_char <= next_cell.ch;
					cell_bus.cell_fg <= next_cell.fg;
					cell_bus.cell_bg <= next_cell.bg;
				end else begin
					cell_bus.valid <= 1'b0;
				end
			end
			text_bus.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Monitor: checks output bytes and predicts accepted cells on the rising edge.
	always @(posedge clk) begin
		cell_took <= arst_n && cell_bus.valid && cell_bus.ready;
		if (arst_n) begin
			if (text_bus.valid && text_bus.ready) begin
				bytes_checked++;
				if (text_due.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", text_bus.out_byte));
				end else begin
					want = text_due.pop_front();
					if (text_bus.out_byte !== want.code)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							text_bus.out_byte, want.code));
					if (text_bus.run_last !== want.last)
						report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
							text_bus.run_last, want.last, want.code));
				end
			end
			if (cell_bus.valid && cell_bus.ready) begin
				encode_cell({cell_bus.cell_char, cell_bus.cell_fg, cell_bus.cell_bg});
				cells_taken++;
			end
		end
	end

	task automatic queue_cell(input logic [7:0] ch, input logic [3:0] fg, input logic [3:0] bg);
		pending_cells.push_back({ch, fg, bg});
		cells_queued++;
	endtask

	task automatic wait_quiet();
		while (cells_taken != cells_queued || text_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [asde_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.wdata <= val;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		if (idx == asde_pkg::REG_FRAME_ROWS)
			rows_reg = val;
		else if (idx == asde_pkg::REG_FRAME_COLS)
			cols_reg = val;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic set_frame(input logic [7:0] nr, input logic [7:0] nc);
		wait_quiet();
		write_reg(asde_pkg::REG_FRAME_ROWS, nr);
		write_reg(asde_pkg::REG_FRAME_COLS, nc);
	endtask

	function automatic cell_t rand_cell();
		cell_t c;
		c.ch = 8'($urandom_range(255));
		if ($urandom_range(9) < 7) begin
			c.fg = 4'($urandom_range(2));
			c.bg = 4'($urandom_range(2));
		end else begin
			c.fg = 4'($urandom_range(15));
			c.bg = 4'($urandom_range(15));
		end
		if ($urandom_range(19) == 0)
			c = '0;
		return c;
	endfunction

	task automatic queue_frame(input int nr, input int nc, input int keep);
		cell_t c;
		for (int idx = 0; idx < nr * nc; idx++) begin
			if ($urandom_range(99) < keep)
				c = gen_image[idx];
			else
				c = rand_cell();
			gen_image[idx] = c;
			queue_cell(c.ch, c.fg, c.bg);
			random_cells++;
		end
	endtask

	initial begin
		int nr, nc, keep;
		arst_n = 1'b0;
		cell_bus.valid = 1'b0;
		cell_bus.cell_char = '0;
		cell_bus.cell_fg = '0;
		cell_bus.cell_bg = '0;
		text_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.reg_index = '0;
		cfg_bus.wdata = '0;
		foreach (shadow_mirror[i])
			shadow_mirror[i] = '0;
		rows_reg = asde_pkg::ROWS_RESET;
		cols_reg = asde_pkg::COLS_RESET;
		at_row = '0;
		at_col = '0;
		cur_valid = 1'b0;
		cur_row = '0;
		cur_col = '0;
		pen_valid = 1'b0;
		pen_fg = '0;
		pen_bg = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default size: blank cells match the cleared shadow, color and cursor reuse.
		queue_cell(8'h00, 4'd0, 4'd0);
		queue_cell(8'hFF, 4'd15, 4'd15);
		queue_cell(8'h41, 4'd8, 4'd8);
		queue_cell(8'h42, 4'd8, 4'd8);
		queue_cell(8'h00, 4'd0, 4'd0);
		queue_cell(8'h43, 4'd1, 4'd0);

		// A zero size acts as one, so the next cell closes the frame mid-row.
		wait_quiet();
		write_reg(asde_pkg::REG_FRAME_ROWS, 8'h00);
		write_reg(asde_pkg::REG_FRAME_COLS, 8'h00);
		write_reg(REG_SPARE, 8'h55);
		write_reg(REG_TOP, 8'hAA);
		queue_cell(8'h44, 4'd0, 4'd0);

		// One column per row walks the row down inside the store; then wide rows land beyond it.
		set_frame(8'hFF, 8'h01);
		queue_cell(8'h00, 4'd0, 4'd0);
		queue_cell(8'hFF, 4'd15, 4'd15);
		for (int i = 2; i < 9; i++)
			queue_cell(8'h60 + 8'(i), 4'(i), 4'(8 - i));
		wait_quiet();
		write_reg(asde_pkg::REG_FRAME_COLS, 8'hFF);
		queue_cell(8'h00, 4'd0, 4'd0);
		queue_cell(8'h00, 4'd0, 4'd0);
		queue_cell(8'h5A, 4'd9, 4'd12);
		set_frame(8'h01, 8'h01);
		queue_cell(8'h45, 4'd0, 4'd0);

		wait_quiet();
		foreach (gen_image[i])
			gen_image[i] = shadow_mirror[i];

		// Tall and wide frames reach three-digit cursor positions.
		set_frame(8'd105, 8'd1);
		queue_frame(105, 1, 60);
		set_frame(8'd1, 8'd205);
		no_gaps = 1'b1;
		queue_frame(1, 205, 60);
		wait_quiet();
		no_gaps = 1'b0;

		while (random_cells < RANDOM_CELLS) begin
			nr = ($urandom_range(3) == 0) ? 1 : $urandom_range(6, 1);
			nc = $urandom_range(14, 1);
			set_frame(8'(nr), 8'(nc));
			if ($urandom_range(3) == 0)
				write_reg(($urandom_range(1) == 0) ? REG_SPARE : REG_TOP,
					8'($urandom_range(255)));
			repeat ($urandom_range(4, 1)) begin
				case ($urandom_range(4))
					0: keep = 0;
					1: keep = 40;
					2: keep = 75;
					3: keep = 95;
					default: keep = 100;
				endcase
				queue_frame(nr, nc, keep);
			end
		end

		wait_quiet();
		$display("Sent %0d cells (%0d in random frames) over %0d completed frames.",
			cells_taken, random_cells, frames_closed);
		$display("Checked %0d output bytes, %0d mismatches.", bytes_checked, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d cells pending and %0d bytes outstanding.",
			cells_queued - cells_taken, text_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: ansi_screen_diff_encoder_core.f
src/asde_pkg.sv
src/asde_chans.sv
src/ansi_screen_diff_encoder_core.sv
verif/testbench.sv
